@@ rtl/d2h_pkg.sv @@
// ----------------------------------------------------------------------------
// d2h_pkg: shared constants and types for the binary64 to binary16 converter
// Holds format field widths, special encodings and the decode record.
// ----------------------------------------------------------------------------
package d2h_pkg;

   localparam int unsigned DBL_W      = 64;
   localparam int unsigned HALF_W     = 16;
   localparam logic [10:0] EXP_ALL1   = 11'h7FF;
   localparam logic [15:0] HALF_INF   = 16'h7C00;
   localparam logic [15:0] NAN_RESET  = 16'h7E00;
   localparam int          EXP_BIAS64 = 1023;
   localparam int          SUBNORM_MIN = -25;
   localparam int          NORMAL_MIN  = -14;
   localparam int          SUBNORM_BASE = 28;
   localparam int          NORMAL_SHIFT = 42;

   typedef enum logic [1:0] {
      CLS_ZERO,
      CLS_INF,
      CLS_NAN,
      CLS_FINITE
   } cls_type;

   // Decoded operand handed from the input stage to the rounding stage.
   typedef struct packed {
      logic        sign;
      cls_type     cls;
      logic [10:0] ebits;
      logic [52:0] sig;
   } dec_type;

endpackage

@@ rtl/d2h_round.sv @@
// ----------------------------------------------------------------------------
// d2h_round: rounding and packing of one decoded operand
// Right shift with round to nearest even, then exponent, overflow and packing.
// ----------------------------------------------------------------------------
module d2h_round (
   input  d2h_pkg::dec_type dec,
   input  logic [15:0]      canonical_nan,
   output logic [15:0]      half_bits
);

   logic signed [12:0] e;
   logic [5:0]         sh;
   logic [52:0]        q;
   logic [52:0]        rem;
   logic [52:0]        halfw;
   logic [52:0]        mask;
   logic [11:0]        r;
   logic [5:0]         he;
   logic [15:0]        sgn;

   always_comb begin
      e     = $signed({2'b00, dec.ebits}) - 13'sd1023;
      sgn   = {dec.sign, 15'd0};
      if (e < 13'(d2h_pkg::NORMAL_MIN)) begin
         sh = 6'(13'(d2h_pkg::SUBNORM_BASE) - e);
      end else begin
         sh = 6'(d2h_pkg::NORMAL_SHIFT);
      end
      q     = dec.sig >> sh;
      mask  = (53'd1 << sh) - 53'd1;
      rem   = dec.sig & mask;
      halfw = 53'd1 << (sh - 6'd1);
      r     = 12'(q);
      if (rem > halfw || (rem == halfw && q[0])) begin
         r = r + 12'd1;
      end
      he = 6'(e + 13'sd15);
      half_bits = sgn;
      case (dec.cls)
         d2h_pkg::CLS_NAN:  half_bits = canonical_nan;
         d2h_pkg::CLS_INF:  half_bits = sgn | d2h_pkg::HALF_INF;
         d2h_pkg::CLS_ZERO: half_bits = sgn;
         d2h_pkg::CLS_FINITE: begin
            if (e < 13'(d2h_pkg::SUBNORM_MIN)) begin
               half_bits = sgn;
            end else if (e < 13'(d2h_pkg::NORMAL_MIN)) begin
               // A carry into bit 10 naturally encodes the smallest normal.
               half_bits = sgn | {5'd0, r[10:0]};
            end else if (e > 13'sd15) begin
               half_bits = sgn | d2h_pkg::HALF_INF;
            end else begin
               if (r == 12'h800) begin
                  r  = 12'h400;
                  he = he + 6'd1;
               end
               if (he >= 6'h1F) begin
                  half_bits = sgn | d2h_pkg::HALF_INF;
               end else begin
                  half_bits = sgn | {1'b0, he[4:0], r[9:0]};
               end
            end
         end
         default: half_bits = sgn;
      endcase
   end

endmodule

@@ rtl/double_to_half_convert_unit.sv @@
// ----------------------------------------------------------------------------
// double_to_half_convert_unit: binary64 to binary16 conversion
// Input register, decode and round logic, result register with skid stage.
// ----------------------------------------------------------------------------
// Converts one binary64 pattern per item to binary16, rounding to nearest
// even. The input register is decoded and rounded in a single pass into the
// result register, or the skid stage if stalled. One item is accepted
// every cycle while req_ready is high; a stalled result side is absorbed by a
// one-entry skid stage, so req_ready drops only once both stages are full.
// csr_wr_en writes the NaN pattern and should be used only while idle.
module double_to_half_convert_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_double_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_half_bits,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic             in_vld_ff;
   logic [63:0]      in_data_ff;
   logic             out_vld_ff;
   logic [15:0]      out_data_ff;
   logic             skid_vld_ff;
   logic [15:0]      skid_data_ff;
   logic [15:0]      nan_ff;
   d2h_pkg::dec_type dec;
   logic [15:0]      half_bits;
   logic             adv;

   always_comb begin
      dec.sign  = in_data_ff[63];
      dec.ebits = in_data_ff[62:52];
      dec.sig   = {1'b1, in_data_ff[51:0]};
      if (dec.ebits == d2h_pkg::EXP_ALL1) begin
         dec.cls = (in_data_ff[51:0] == 52'd0) ? d2h_pkg::CLS_INF : d2h_pkg::CLS_NAN;
      end else if (dec.ebits == 11'd0) begin
         dec.cls = d2h_pkg::CLS_ZERO;
      end else begin
         dec.cls = d2h_pkg::CLS_FINITE;
      end
   end

   d2h_round u_round (
      .dec           (dec),
      .canonical_nan (nan_ff),
      .half_bits     (half_bits)
   );

   // The input stage moves on unless the skid stage is occupied.
   assign req_ready     = !skid_vld_ff;
   assign adv           = in_vld_ff && !skid_vld_ff;
   assign rsp_valid     = out_vld_ff;
   assign rsp_half_bits = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
         nan_ff      <= d2h_pkg::NAN_RESET;
      end else begin
         if (csr_wr_en) begin
            nan_ff <= csr_wr_data;
         end
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (!out_vld_ff || rsp_ready) begin
            if (skid_vld_ff) begin
               out_vld_ff  <= 1'b1;
               skid_vld_ff <= 1'b0;
            end else begin
               out_vld_ff <= adv;
            end
         end else if (adv) begin
            skid_vld_ff <= 1'b1;
         end
      end
      if (req_ready) begin
         in_data_ff <= req_double_bits;
      end
      if (!out_vld_ff || rsp_ready) begin
         out_data_ff <= skid_vld_ff ? skid_data_ff : half_bits;
      end else if (adv) begin
         skid_data_ff <= half_bits;
      end
   end

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff) else $error("skid full without result");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_ready) |=> (out_vld_ff && $stable(out_data_ff)))
      else $error("stalled result changed");
   a_in_to_out: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !skid_vld_ff && (!out_vld_ff || rsp_ready)) |=> out_vld_ff)
      else $error("item lost between stages");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: binary64 to binary16 converter check
// Drives binary64 patterns through the converter with random idling on both
// sides, predicts each binary16 result and compares results in order.
// ----------------------------------------------------------------------------
module testbench;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_double_bits;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_half_bits;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   logic [63:0] pending_doubles[$];
   logic [15:0] expected_halves[$];
   logic [15:0] nan_pattern;
   int          mismatch_count;
   int          send_gap;
   int          hold_gap;
   int          long_hold;
   bit          quiet_phase;

   double_to_half_convert_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_double_bits(req_double_bits),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_half_bits(rsp_half_bits),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Shift right rounding to nearest, ties to even.
   function automatic logic [63:0] round_shift(logic [63:0] v, int sh);
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      q = v >> sh;
      rem = v & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      return q;
   endfunction

   function automatic logic [15:0] to_half(logic [63:0] d);
      logic [15:0] sgn;
      logic [10:0] eb;
      logic [63:0] sig;
      logic [63:0] r;
      int          e;
      int          he;
      sgn = {d[63], 15'd0};
      eb = d[62:52];
      if (eb == d2h_pkg::EXP_ALL1)
         return (d[51:0] == 0) ? (sgn | d2h_pkg::HALF_INF) : nan_pattern;
      if (eb == 0) return sgn;
      e = int'(eb) - d2h_pkg::EXP_BIAS64;
      sig = {11'd1, d[51:0]};
      if (e < d2h_pkg::SUBNORM_MIN) return sgn;
      if (e < d2h_pkg::NORMAL_MIN) begin
         r = round_shift(sig, d2h_pkg::SUBNORM_BASE - e);
         return sgn | r[15:0];
      end
      if (e > 15) return sgn | d2h_pkg::HALF_INF;
      r = round_shift(sig, d2h_pkg::NORMAL_SHIFT);
      he = e + 15;
      if (r == 64'h800) begin
         r = 64'h400;
         he = he + 1;
      end
      if (he >= 31) return sgn | d2h_pkg::HALF_INF;
      return sgn | 16'(he << 10) | {6'd0, r[9:0]};
   endfunction

   function automatic logic [63:0] make_double(bit s, int e, logic [51:0] f);
      return {s, 11'(e + d2h_pkg::EXP_BIAS64), f};
   endfunction

   function automatic logic [63:0] random_double();
      logic [63:0] d;
      int          e;
      d = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: d[62:52] = d2h_pkg::EXP_ALL1;
         1: d[62:52] = 11'd0;
         2: d[62:52] = 11'($urandom_range(0, 2047));
         default: begin
            e = $urandom_range(0, 45) - 28;
            d[62:52] = 11'(e + d2h_pkg::EXP_BIAS64);
            // Push the fraction near rounding ties now and then.
            if ($urandom_range(0, 3) == 0) d[41:0] = {1'b1, 41'd0} ^ 42'($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0) d[51:42] = 10'h3FF;
         end
      endcase
      return d;
   endfunction

   // Queues are checked away from the rising edge so that a pop and its push
   // at the same edge are both seen.
   task automatic drain();
      while (pending_doubles.size() != 0 || expected_halves.size() != 0) @(negedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_nan(logic [15:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      nan_pattern = v;
   endtask

   // Sender: offers the oldest pending item, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (req_valid && !req_ready) begin
      end else begin
         if (req_valid) void'(pending_doubles.pop_front());
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_doubles.size() > 0) begin
            req_valid <= 1'b1;
            req_double_bits <= pending_doubles[0];
            if (!quiet_phase && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_gap <= 0;
      end else if (long_hold > 0) begin
         rsp_ready <= 1'b0;
         long_hold <= long_hold - 1;
      end else if (hold_gap > 0) begin
         rsp_ready <= 1'b0;
         hold_gap <= hold_gap - 1;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         hold_gap <= $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Predict at acceptance; compare at result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) expected_halves.push_back(to_half(req_double_bits));
         if (rsp_valid && rsp_ready) begin
            if (expected_halves.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected item: half %h", rsp_half_bits);
            end else begin
               if (rsp_half_bits !== expected_halves[0]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %h actual %h", expected_halves[0],
                              rsp_half_bits);
               end
               void'(expected_halves.pop_front());
            end
         end
      end
   end

   initial begin
      logic [15:0] nan_settings[4];
      int          k;
      nan_settings = '{16'h0000, 16'hFFFF, 16'h7E01, 16'h7E00};
      reset = 1'b1;
      req_valid = 1'b0;
      req_double_bits = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      nan_pattern = d2h_pkg::NAN_RESET;
      mismatch_count = 0;
      quiet_phase = 1'b0;
      long_hold = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed cases under the reset NaN pattern.
      pending_doubles.push_back(64'h0000_0000_0000_0000);
      pending_doubles.push_back(64'h8000_0000_0000_0000);
      pending_doubles.push_back(64'h0000_0000_0000_0001);
      pending_doubles.push_back(64'h800F_FFFF_FFFF_FFFF);
      pending_doubles.push_back(64'h7FF0_0000_0000_0000);
      pending_doubles.push_back(64'hFFF0_0000_0000_0000);
      pending_doubles.push_back(64'h7FF8_0000_0000_0000);
      pending_doubles.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      pending_doubles.push_back(64'h7FF0_0000_0000_0001);
      pending_doubles.push_back(make_double(0, -26, 52'hFFFFF_FFFFFFFF));
      pending_doubles.push_back(make_double(0, -25, 52'd0));
      pending_doubles.push_back(make_double(1, -25, 52'd1));
      pending_doubles.push_back(make_double(0, -15, 52'hFFFFF_FFFFFFFF));
      pending_doubles.push_back(make_double(0, -24, 52'h80000_00000000));
      pending_doubles.push_back(make_double(0, -14, 52'd0));
      pending_doubles.push_back(make_double(0, 0, 52'd0));
      pending_doubles.push_back(make_double(0, 0, {10'd0, 1'b1, 41'd0}));
      pending_doubles.push_back(make_double(0, 0, {10'd1, 1'b1, 41'd0}));
      pending_doubles.push_back(make_double(1, 15, {10'h3FF, 42'd0}));
      pending_doubles.push_back(make_double(0, 15, {10'h3FF, 1'b1, 41'd0}));
      pending_doubles.push_back(make_double(0, 16, 52'd0));
      pending_doubles.push_back(64'h7FEF_FFFF_FFFF_FFFF);
      pending_doubles.push_back(make_double(0, 3, 52'h3FFFF_FFFFFFFF));
      drain();

      // Long receiver hold-off while the sender keeps offering items.
      for (k = 0; k < 40; k++) pending_doubles.push_back(random_double());
      long_hold = 60;
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_nan(nan_settings[phase]);
         if (phase == 3) quiet_phase = 1'b1;
         for (k = 0; k < 500; k++) pending_doubles.push_back(random_double());
         drain();
      end
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_halves.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/d2h_pkg.sv
rtl/d2h_round.sv
rtl/double_to_half_convert_unit.sv
tb/testbench.sv
